FILE: sv/ispce_pkg.sv
// Shared constants, types and helpers of the ISP programming command engine.
`timescale 1ns / 1ps
package ispce_pkg;

    localparam int BufferDepth = 256;
    localparam int PageWords   = 64;

    localparam int AddrW  = $clog2(BufferDepth);
    localparam int PlenW  = $clog2(BufferDepth + 1);
    localparam int CntW   = ($clog2(BufferDepth + 3) > 5) ? $clog2(BufferDepth + 3) : 5;
    localparam int PwcW   = $clog2(PageWords + 1);

    localparam int MaxRes  = 9;
    localparam int ResCntW = $clog2(MaxRes + 1);

    // input opcodes
    localparam logic [1:0] OpHost = 2'd0;
    localparam logic [1:0] OpDone = 2'd1;
    localparam logic [1:0] OpTick = 2'd2;

    // result kinds
    localparam logic [3:0] KTx        = 4'd0;
    localparam logic [3:0] KEeWrite   = 4'd1;
    localparam logic [3:0] KEeRead    = 4'd2;
    localparam logic [3:0] KFlashRead = 4'd3;
    localparam logic [3:0] KErase     = 4'd4;
    localparam logic [3:0] KRww       = 4'd5;
    localparam logic [3:0] KFill      = 4'd6;
    localparam logic [3:0] KPageWrite = 4'd7;
    localparam logic [3:0] KStartApp  = 4'd8;
    localparam logic [3:0] KReset     = 4'd9;

    // protocol bytes
    localparam logic [7:0] SyncEop  = 8'h20;
    localparam logic [7:0] RespSync = 8'h14;
    localparam logic [7:0] RespOk   = 8'h10;
    localparam logic [7:0] MemEeprom = 8'h45;
    localparam logic [7:0] DevExtThresh = 8'h85;
    localparam logic [7:0] UnivReadSig = 8'h30;
    localparam logic [7:0] ParamHwVer  = 8'h80;
    localparam logic [7:0] ParamSwMaj  = 8'h81;
    localparam logic [7:0] ParamSwMin  = 8'h82;
    localparam logic [7:0] ParamTopCard = 8'h98;
    localparam logic [7:0] TopCardValue = 8'h03;

    // commands
    localparam logic [7:0] CmdGetSync   = 8'h30;
    localparam logic [7:0] CmdSignOn    = 8'h31;
    localparam logic [7:0] CmdSetParam  = 8'h40;
    localparam logic [7:0] CmdGetParam  = 8'h41;
    localparam logic [7:0] CmdSetDevice = 8'h42;
    localparam logic [7:0] CmdSetDevExt = 8'h45;
    localparam logic [7:0] CmdEnterProg = 8'h50;
    localparam logic [7:0] CmdLeaveProg = 8'h51;
    localparam logic [7:0] CmdChipErase = 8'h52;
    localparam logic [7:0] CmdLoadAddr  = 8'h55;
    localparam logic [7:0] CmdUniversal = 8'h56;
    localparam logic [7:0] CmdProgPage  = 8'h64;
    localparam logic [7:0] CmdReadPage  = 8'h74;
    localparam logic [7:0] CmdReadSig   = 8'h75;
    localparam logic [7:0] CmdReadOsc   = 8'h76;

    // config register indexes
    localparam logic [2:0] RegMaxErr  = 3'd0;
    localparam logic [2:0] RegTimeout = 3'd1;
    localparam logic [2:0] RegHwVer   = 3'd2;
    localparam logic [2:0] RegSwMaj   = 3'd3;
    localparam logic [2:0] RegSwMin   = 3'd4;
    localparam logic [2:0] RegSig     = 3'd5;

    localparam logic [7:0] SignOnText [7] = '{8'h41, 8'h56, 8'h52, 8'h20, 8'h49, 8'h53, 8'h50};

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] mem_address;
        logic [15:0] payload;
    } t_result;

    typedef struct packed {
        t_result [MaxRes-1:0] item;
        logic [ResCntW-1:0]   count;
    } t_res_list;

    function automatic t_res_list push(input t_res_list l, input logic [3:0] k,
                                       input logic [15:0] a, input logic [15:0] p);
        t_res_list r;
        r = l;
        if (r.count < ResCntW'(MaxRes)) begin
            r.item[r.count[ResCntW-1:0]] = '{kind: k, mem_address: a, payload: p};
            r.count = r.count + 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: sv/ispce_in_if.sv
// Input channel: opcode and value of one item with valid/ready.
`timescale 1ns / 1ps
interface ispce_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

FILE: sv/ispce_out_if.sv
// Output channel: one result item with valid/ready.
`timescale 1ns / 1ps
interface ispce_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] mem_address;
    logic [15:0] payload;
    logic        last;

    modport source (output valid, output kind, output mem_address, output payload,
                    output last, input ready);
    modport sink   (input valid, input kind, input mem_address, input payload,
                    input last, output ready);
endinterface

FILE: sv/ispce_result_queue.sv
// Result queue: holds the results of one item and feeds the output register.
`timescale 1ns / 1ps
module ispce_result_queue
    import ispce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_res_list   i_list,
    output logic        o_can_load,
    ispce_out_if.source o_rsp
);

    typedef struct packed {
        t_result res;
        logic    last;
    } t_entry;

    t_entry             r_q [MaxRes];
    logic [ResCntW-1:0] r_cnt;
    logic               w_out_free;
    logic               w_pop;

    assign w_out_free = !o_rsp.valid || o_rsp.ready;
    assign w_pop      = (r_cnt != '0) && w_out_free;
    assign o_can_load = (r_cnt == '0) || ((r_cnt == ResCntW'(1)) && w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_list.count;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MaxRes; i++) begin
            if (i_load) begin
                r_q[i].res  <= i_list.item[i];
                r_q[i].last <= (ResCntW'(i + 1) == i_list.count);
            end else if (w_pop && i < MaxRes - 1) begin
                r_q[i] <= r_q[i + 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_rsp.valid <= 1'b0;
        end else if (w_pop) begin
            o_rsp.valid <= 1'b1;
        end else if (o_rsp.ready) begin
            o_rsp.valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            o_rsp.kind        <= r_q[0].res.kind;
            o_rsp.mem_address <= r_q[0].res.mem_address;
            o_rsp.payload     <= r_q[0].res.payload;
            o_rsp.last        <= r_q[0].last;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ResCntW'(MaxRes))
        else $error("result count out of range");

    a_load_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("load while queue busy");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_cnt == $past(i_list.count))
        else $error("queue count mismatch after load");

    a_pop_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_rsp.valid)
        else $error("popped entry not presented");

endmodule

FILE: sv/isp_programming_command_engine.sv
// Top level of the ISP programming command engine.
`timescale 1ns / 1ps
// Usage:
//   i_cmd carries one item per handshake: opcode 0 is a host protocol byte,
//   1 a memory action completion (value = read data), 2 one timer tick.
//   o_rsp gives result items: tx bytes, memory actions, startapp or reset;
//   the last result caused by an input item carries last = 1.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data,
//   one register per write; the user must write only while the engine is idle (not checked).
// Timing:
//   Each item is parsed in the cycle it is accepted; its results are loaded
//   into a small queue, then pass one per cycle through the output register
//   to o_rsp while the receiver is ready. An item is accepted every cycle as
//   long as each one causes at most one result and the receiver keeps up; an
//   item with more results holds the input while the output register drains them.
//   The page buffer is a 256 x 8 RAM with two registered read ports that
//   prefetch the bytes needed by the next EEPROM write or flash fill.
// Reset and stalls:
//   Synchronous reset returns to wait-command with all counters cleared and
//   the config registers at their defaults. The page buffer is not cleared.
//   A stalled receiver holds the output register; one more item is still
//   accepted behind it, then i_cmd.ready drops until the queue drains.
//   After startapp or reset results the engine ignores all input items.
module isp_programming_command_engine
    import ispce_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ispce_in_if.sink    i_cmd,
    ispce_out_if.source o_rsp,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    // parser phases
    localparam logic [3:0] PhCmd   = 4'd0;
    localparam logic [3:0] PhArgs  = 4'd1;
    localparam logic [3:0] PhTerm  = 4'd2;
    localparam logic [3:0] PhData  = 4'd3;
    localparam logic [3:0] PhEew   = 4'd4;
    localparam logic [3:0] PhErase = 4'd5;
    localparam logic [3:0] PhRww1  = 4'd6;
    localparam logic [3:0] PhFill  = 4'd7;
    localparam logic [3:0] PhPgw   = 4'd8;
    localparam logic [3:0] PhRww2  = 4'd9;
    localparam logic [3:0] PhRead  = 4'd10;

    // configuration
    logic [7:0]  r_max_err;
    logic [23:0] r_timeout;
    logic [7:0]  r_hw_ver;
    logic [7:0]  r_sw_maj;
    logic [7:0]  r_sw_min;
    logic [23:0] r_sig;

    // parser state
    logic [3:0]       r_phase, n_phase;
    logic [7:0]       r_cmd, n_cmd;
    logic [CntW-1:0]  r_bc, n_bc;
    logic [PlenW-1:0] r_plen, n_plen;
    logic [15:0]      r_addr, n_addr;
    logic [7:0]       r_err, n_err;
    logic [23:0]      r_idle, n_idle;
    logic             r_ee, n_ee;
    logic [PwcW-1:0]  r_pwc, n_pwc;
    logic [7:0]       r_h0, n_h0;
    logic [7:0]       r_h1, n_h1;
    logic             r_halted, n_halted;

    // page buffer
    logic [7:0]       mem [BufferDepth];
    logic [7:0]       r_rd_a, r_rd_b;
    logic [AddrW-1:0] w_pa_a, w_pa_b;
    logic [CntW-1:0]  w_pa;
    logic             w_wr_en;
    logic [AddrW-1:0] w_wr_addr;
    logic [7:0]       w_wr_data;

    logic       w_accept;
    logic       w_can_load;
    t_res_list  w_list;
    logic       w_do_err, w_rst_after, w_do_adv;
    logic [7:0] w_v;

    assign w_v         = i_cmd.value;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = w_can_load;

    function automatic logic [4:0] args_needed(input logic [7:0] c, input logic [7:0] h0);
        case (c)
            CmdSetParam:  return (h0 > DevExtThresh) ? 5'd2 : 5'd1;
            CmdGetParam:  return 5'd1;
            CmdSetDevice: return 5'd20;
            CmdSetDevExt: return 5'd5;
            CmdLoadAddr:  return 5'd2;
            CmdUniversal: return 5'd4;
            CmdProgPage:  return 5'd3;
            CmdReadPage:  return 5'd3;
            default:      return 5'd0;
        endcase
    endfunction

    function automatic logic known_cmd(input logic [7:0] c);
        case (c)
            CmdGetSync, CmdSignOn, CmdSetParam, CmdGetParam, CmdSetDevice,
            CmdSetDevExt, CmdEnterProg, CmdLeaveProg, CmdChipErase, CmdLoadAddr,
            CmdUniversal, CmdProgPage, CmdReadPage, CmdReadSig, CmdReadOsc:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] sig_byte(input logic [23:0] s, input logic [1:0] k);
        case (k)
            2'd0:    return s[23:16];
            2'd1:    return s[15:8];
            default: return s[7:0];
        endcase
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_err <= 8'd10;
            r_timeout <= 24'd1000000;
            r_hw_ver  <= 8'd2;
            r_sw_maj  <= 8'd1;
            r_sw_min  <= 8'd16;
            r_sig     <= 24'h1E950F;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegMaxErr:  r_max_err <= i_cfg_data[7:0];
                RegTimeout: r_timeout <= i_cfg_data;
                RegHwVer:   r_hw_ver  <= i_cfg_data[7:0];
                RegSwMaj:   r_sw_maj  <= i_cfg_data[7:0];
                RegSwMin:   r_sw_min  <= i_cfg_data[7:0];
                RegSig:     r_sig     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // one parse step per accepted item
    always_comb begin
        logic [4:0]       need;
        logic [CntW-1:0]  bc1;
        logic [PlenW-1:0] pl;
        logic [15:0]      len;
        logic [15:0]      a2;
        logic [7:0]       rsel;
        logic [PwcW-1:0]  pwc1;

        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_bc     = r_bc;
        n_plen   = r_plen;
        n_addr   = r_addr;
        n_err    = r_err;
        n_idle   = r_idle;
        n_ee     = r_ee;
        n_pwc    = r_pwc;
        n_h0     = r_h0;
        n_h1     = r_h1;
        n_halted = r_halted;
        w_list   = '0;
        w_do_err = 1'b0;
        w_rst_after = 1'b0;
        w_do_adv = 1'b0;
        w_wr_en  = 1'b0;
        w_wr_addr = '0;
        w_wr_data = '0;
        need = '0;
        bc1  = '0;
        pl   = '0;
        len  = '0;
        a2   = '0;
        rsel = '0;
        pwc1 = '0;

        if (w_accept && !r_halted) begin
            case (i_cmd.opcode)
                OpHost: begin
                    n_idle = '0;
                    case (r_phase)
                        PhCmd: begin
                            n_cmd = w_v;
                            n_bc  = '0;
                            n_h0  = '0;
                            n_h1  = '0;
                            if (!known_cmd(w_v)) begin
                                w_do_err = 1'b1;
                            end else begin
                                n_phase = (args_needed(w_v, 8'd0) == 5'd0) ? PhTerm : PhArgs;
                            end
                        end
                        PhArgs: begin
                            if (r_bc == '0) n_h0 = w_v;
                            if (r_cmd == CmdLoadAddr && r_bc == CntW'(1))
                                n_addr = {w_v, r_h0};
                            if (r_cmd == CmdUniversal && r_bc == CntW'(2)) begin
                                n_h1 = (r_h0 == UnivReadSig) ?
                                       sig_byte(r_sig, (w_v == 8'd0) ? 2'd0 :
                                                       ((w_v == 8'd1) ? 2'd1 : 2'd2)) : 8'd0;
                            end
                            if ((r_cmd == CmdProgPage || r_cmd == CmdReadPage) &&
                                r_bc == CntW'(1)) begin
                                len = {r_h0, w_v};
                                n_plen = (len > 16'(BufferDepth)) ? PlenW'(BufferDepth)
                                                                 : len[PlenW-1:0];
                            end
                            if ((r_cmd == CmdProgPage || r_cmd == CmdReadPage) &&
                                r_bc == CntW'(2)) begin
                                n_ee = (w_v == MemEeprom);
                                if (r_cmd == CmdReadPage) n_addr = {r_addr[14:0], 1'b0};
                            end
                            n_bc = r_bc + 1'b1;
                            need = args_needed(r_cmd, n_h0);
                            if (n_bc >= CntW'(need)) begin
                                if (r_cmd == CmdProgPage && n_plen != '0) begin
                                    n_bc    = '0;
                                    n_phase = PhData;
                                end else begin
                                    n_phase = PhTerm;
                                end
                            end
                        end
                        PhData: begin
                            if (r_bc < CntW'(BufferDepth)) begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = r_bc[AddrW-1:0];
                                w_wr_data = w_v;
                            end
                            n_bc = r_bc + 1'b1;
                            if (n_bc >= CntW'(r_plen)) n_phase = PhTerm;
                        end
                        PhTerm: begin
                            if (w_v != SyncEop) begin
                                w_do_err    = 1'b1;
                                w_rst_after = (r_cmd == CmdLeaveProg);
                            end else begin
                                n_phase = PhCmd;
                                case (r_cmd)
                                    CmdSignOn: begin
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        for (int i = 0; i < 7; i++)
                                            w_list = push(w_list, KTx, '0, {8'd0, SignOnText[i]});
                                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    end
                                    CmdGetParam: begin
                                        case (r_h0)
                                            ParamHwVer:   rsel = r_hw_ver;
                                            ParamSwMaj:   rsel = r_sw_maj;
                                            ParamSwMin:   rsel = r_sw_min;
                                            ParamTopCard: rsel = TopCardValue;
                                            default:      rsel = 8'd0;
                                        endcase
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        w_list = push(w_list, KTx, '0, {8'd0, rsel});
                                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    end
                                    CmdLeaveProg: begin
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                        w_list = push(w_list, KReset, '0, '0);
                                        n_halted = 1'b1;
                                    end
                                    CmdUniversal: begin
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        w_list = push(w_list, KTx, '0, {8'd0, r_h1});
                                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    end
                                    CmdProgPage: begin
                                        a2     = {r_addr[14:0], 1'b0};
                                        n_addr = a2;
                                        n_bc   = '0;
                                        if (r_ee) begin
                                            if (r_plen == '0) begin
                                                w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                                w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                            end else begin
                                                w_list = push(w_list, KEeWrite, a2, {8'd0, r_rd_a});
                                                n_phase = PhEew;
                                            end
                                        end else begin
                                            pl = r_plen;
                                            if (pl[0]) begin
                                                // odd length: pad the last word
                                                w_wr_en   = 1'b1;
                                                w_wr_addr = pl[AddrW-1:0];
                                                w_wr_data = 8'hFF;
                                                pl = pl + 1'b1;
                                            end
                                            n_plen = pl;
                                            if (pl == '0) begin
                                                w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                                w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                            end else begin
                                                n_pwc  = '0;
                                                w_list = push(w_list, KErase, a2, '0);
                                                n_phase = PhErase;
                                            end
                                        end
                                    end
                                    CmdReadPage: begin
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        n_bc = '0;
                                        if (r_plen == '0) begin
                                            w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                        end else begin
                                            w_list = push(w_list, r_ee ? KEeRead : KFlashRead,
                                                          r_addr, '0);
                                            n_phase = PhRead;
                                        end
                                    end
                                    CmdReadSig: begin
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        w_list = push(w_list, KTx, '0, {8'd0, r_sig[23:16]});
                                        w_list = push(w_list, KTx, '0, {8'd0, r_sig[15:8]});
                                        w_list = push(w_list, KTx, '0, {8'd0, r_sig[7:0]});
                                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    end
                                    CmdReadOsc: begin
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        w_list = push(w_list, KTx, '0, 16'd0);
                                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    end
                                    default: begin
                                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    end
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
                OpDone: begin
                    if (r_phase >= PhEew) begin
                        n_idle = '0;
                        case (r_phase)
                            PhEew: begin
                                bc1  = r_bc + 1'b1;
                                n_bc = bc1;
                                if (bc1 < CntW'(r_plen)) begin
                                    w_list = push(w_list, KEeWrite, r_addr + 16'(bc1),
                                                  {8'd0, r_rd_a});
                                end else begin
                                    w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                                    w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    n_phase = PhCmd;
                                end
                            end
                            PhErase: begin
                                w_list  = push(w_list, KRww, r_addr, '0);
                                n_phase = PhRww1;
                            end
                            PhRww1: begin
                                w_list  = push(w_list, KFill, r_addr, {r_rd_b, r_rd_a});
                                n_phase = PhFill;
                            end
                            PhFill: begin
                                pwc1 = r_pwc + 1'b1;
                                if (pwc1 >= PwcW'(PageWords)) begin
                                    n_pwc   = '0;
                                    w_list  = push(w_list, KPageWrite, r_addr, '0);
                                    n_phase = PhPgw;
                                end else begin
                                    n_pwc    = pwc1;
                                    w_do_adv = 1'b1;
                                end
                            end
                            PhPgw: begin
                                w_list  = push(w_list, KRww, r_addr, '0);
                                n_phase = PhRww2;
                            end
                            PhRww2: begin
                                w_do_adv = 1'b1;
                            end
                            PhRead: begin
                                w_list = push(w_list, KTx, '0, {8'd0, w_v});
                                n_addr = r_addr + 16'd1;
                                bc1    = r_bc + 1'b1;
                                n_bc   = bc1;
                                if (bc1 < CntW'(r_plen)) begin
                                    w_list = push(w_list, r_ee ? KEeRead : KFlashRead,
                                                  n_addr, '0);
                                end else begin
                                    w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                                    n_phase = PhCmd;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                OpTick: begin
                    if (r_phase < PhEew) begin
                        if (r_idle != 24'hFFFFFF) n_idle = r_idle + 1'b1;
                        if (n_idle >= r_timeout) begin
                            w_list   = push(w_list, KStartApp, '0, '0);
                            n_halted = 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // step to the next flash word
            if (w_do_adv) begin
                n_addr = r_addr + 16'd2;
                n_bc   = r_bc + CntW'(2);
                pl     = (r_plen > PlenW'(2)) ? r_plen - PlenW'(2) : '0;
                n_plen = pl;
                if (pl == '0) begin
                    if (n_pwc == '0) begin
                        w_list = push(w_list, KTx, '0, {8'd0, RespSync});
                        w_list = push(w_list, KTx, '0, {8'd0, RespOk});
                        n_phase = PhCmd;
                    end else begin
                        // final partial page
                        n_plen  = PlenW'(2);
                        n_pwc   = '0;
                        w_list  = push(w_list, KPageWrite, n_addr, '0);
                        n_phase = PhPgw;
                    end
                end else if (n_pwc == '0) begin
                    w_list  = push(w_list, KErase, n_addr, '0);
                    n_phase = PhErase;
                end else begin
                    w_list  = push(w_list, KFill, n_addr, {r_rd_b, r_rd_a});
                    n_phase = PhFill;
                end
            end

            // error counting, saturating
            if (w_do_err) begin
                if (r_err != 8'hFF) n_err = r_err + 1'b1;
                if (n_err > r_max_err) begin
                    w_list   = push(w_list, KStartApp, '0, '0);
                    n_halted = 1'b1;
                end
                n_phase = PhCmd;
                if (w_rst_after && !n_halted) begin
                    w_list   = push(w_list, KReset, '0, '0);
                    n_halted = 1'b1;
                end
            end
        end
    end

    // prefetch address for the next buffer read
    always_comb begin
        case (n_phase)
            PhEew:   w_pa = n_bc + 1'b1;
            PhRww1:  w_pa = n_bc;
            PhFill:  w_pa = n_bc + CntW'(2);
            default: w_pa = '0;
        endcase
    end

    assign w_pa_a = w_pa[AddrW-1:0];
    assign w_pa_b = w_pa_a + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
        r_rd_a <= (w_wr_en && w_wr_addr == w_pa_a) ? w_wr_data : mem[w_pa_a];
        r_rd_b <= (w_wr_en && w_wr_addr == w_pa_b) ? w_wr_data : mem[w_pa_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhCmd;
            r_cmd    <= '0;
            r_bc     <= '0;
            r_plen   <= '0;
            r_addr   <= '0;
            r_err    <= '0;
            r_idle   <= '0;
            r_ee     <= 1'b0;
            r_pwc    <= '0;
            r_h0     <= '0;
            r_h1     <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_bc     <= n_bc;
            r_plen   <= n_plen;
            r_addr   <= n_addr;
            r_err    <= n_err;
            r_idle   <= n_idle;
            r_ee     <= n_ee;
            r_pwc    <= n_pwc;
            r_h0     <= n_h0;
            r_h1     <= n_h1;
            r_halted <= n_halted;
        end
    end

    ispce_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_list     (w_list),
        .o_can_load (w_can_load),
        .o_rsp      (o_rsp)
    );

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt released without reset");

    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> w_list.count == '0)
        else $error("results while halted");

    a_pwc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pwc < PwcW'(PageWords))
        else $error("page word count out of range");

    a_plen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= PlenW'(BufferDepth))
        else $error("page length above buffer depth");

endmodule

FILE: dv/tb_isp_programming_command_engine.sv
// Self-checking testbench for the ISP programming command engine.
`timescale 1ns / 1ps
module tb_isp_programming_command_engine;
    import ispce_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    // parse phases of the engine, in its own order: the memory phases come last
    typedef enum int {
        PhCmd, PhArgs, PhTerm, PhData, PhEew, PhErase, PhRww1, PhFill, PhPgw,
        PhRww2, PhRead
    } phase_t;

    typedef struct {
        logic [3:0]  kind;
        logic [15:0] mem_address;
        logic [15:0] payload;
        logic        last;
    } rsp_t;

    localparam int WatchdogLimit = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    ispce_in_if  cmd_if ();
    ispce_out_if rsp_if ();

    isp_programming_command_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if.sink),
        .o_rsp       (rsp_if.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: shadow copy of the engine and its registers
    // ------------------------------------------------------------------
    int          cfg_max_err, cfg_timeout, cfg_hw, cfg_sw_maj, cfg_sw_min, cfg_sig;
    phase_t      ph;
    logic [7:0]  cmd_code;
    int          byte_cnt, page_len, err_cnt, idle_cnt, page_words;
    logic [15:0] tgt_addr;
    bit          ee_sel, halted;
    logic [7:0]  held [2];
    logic [7:0]  page_mem [0:BufferDepth];

    rsp_t rsp_expected [$];
    int   fail_count;
    bit   quiet;          // no idling on either side while set

    function automatic void push_rsp(logic [3:0] k, logic [15:0] a, logic [15:0] p);
        rsp_t r;
        r.kind = k;
        r.mem_address = a;
        r.payload = p;
        r.last = 1'b0;
        rsp_expected.push_back(r);
    endfunction

    function automatic void tx(logic [7:0] b);
        push_rsp(KTx, 16'h0, {8'h0, b});
    endfunction

    function automatic logic [7:0] sig_byte(int k);
        return 8'((cfg_sig >> (16 - 8 * k)) & 'hFF);
    endfunction

    function automatic logic [7:0] buf_byte(int i);
        return (i <= BufferDepth) ? page_mem[i] : 8'hFF;
    endfunction

    function automatic void reply_ok();
        tx(RespSync);
        tx(RespOk);
        ph = PhCmd;
    endfunction

    function automatic void reply_byte(logic [7:0] b);
        tx(RespSync);
        tx(b);
        tx(RespOk);
        ph = PhCmd;
    endfunction

    function automatic void count_err();
        if (err_cnt < 255) err_cnt++;
        if (err_cnt > cfg_max_err) begin
            push_rsp(KStartApp, 16'h0, 16'h0);
            halted = 1'b1;
        end
        ph = PhCmd;
    endfunction

    function automatic void flash_fill();
        push_rsp(KFill, tgt_addr, {buf_byte(byte_cnt + 1), buf_byte(byte_cnt)});
        ph = PhFill;
    endfunction

    // a fresh page opens with an erase, otherwise the next word is filled
    function automatic void flash_block();
        if (page_words == 0) begin
            push_rsp(KErase, tgt_addr, 16'h0);
            ph = PhErase;
        end else begin
            flash_fill();
        end
    endfunction

    function automatic void flash_write_page();
        page_words = 0;
        push_rsp(KPageWrite, tgt_addr, 16'h0);
        ph = PhPgw;
    endfunction

    function automatic void flash_advance();
        tgt_addr = tgt_addr + 16'd2;
        byte_cnt += 2;
        page_len = (page_len > 2) ? page_len - 2 : 0;
        if (page_len == 0) begin
            if (page_words == 0) begin
                reply_ok();
            end else begin
                // partial page left: write it, then one more address step
                page_len = 2;
                flash_write_page();
            end
        end else begin
            flash_block();
        end
    endfunction

    function automatic void issue_read();
        push_rsp(ee_sel ? KEeRead : KFlashRead, tgt_addr, 16'h0);
        ph = PhRead;
    endfunction

    function automatic bit known_cmd(logic [7:0] c);
        case (c)
            CmdGetSync, CmdSignOn, CmdSetParam, CmdGetParam, CmdSetDevice,
            CmdSetDevExt, CmdEnterProg, CmdLeaveProg, CmdChipErase, CmdLoadAddr,
            CmdUniversal, CmdProgPage, CmdReadPage, CmdReadSig, CmdReadOsc: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic int arg_count(logic [7:0] c);
        case (c)
            CmdSetParam:  return (held[0] > DevExtThresh) ? 2 : 1;
            CmdGetParam:  return 1;
            CmdSetDevice: return 20;
            CmdSetDevExt: return 5;
            CmdLoadAddr:  return 2;
            CmdUniversal: return 4;
            CmdProgPage:  return 3;
            CmdReadPage:  return 3;
            default:      return 0;
        endcase
    endfunction

    function automatic void take_arg(logic [7:0] v);
        int idx;
        int len;
        idx = byte_cnt;
        if (idx == 0) held[0] = v;
        if (cmd_code == CmdLoadAddr && idx == 1) tgt_addr = {v, held[0]};
        if (cmd_code == CmdUniversal && idx == 2)
            held[1] = (held[0] == UnivReadSig) ? sig_byte(v == 0 ? 0 : (v == 1 ? 1 : 2))
                                               : 8'h0;
        if ((cmd_code == CmdProgPage || cmd_code == CmdReadPage) && idx == 1) begin
            len = {held[0], v};
            page_len = (len > BufferDepth) ? BufferDepth : len;
        end
        if ((cmd_code == CmdProgPage || cmd_code == CmdReadPage) && idx == 2) begin
            ee_sel = (v == MemEeprom);
            if (cmd_code == CmdReadPage) tgt_addr = tgt_addr << 1;
        end
        byte_cnt = idx + 1;
        if (byte_cnt >= arg_count(cmd_code)) begin
            if (cmd_code == CmdProgPage && page_len > 0) begin
                byte_cnt = 0;
                ph = PhData;
            end else begin
                ph = PhTerm;
            end
        end
    endfunction

    function automatic void terminate(logic [7:0] v);
        logic [7:0] r;
        if (v != SyncEop) begin
            count_err();
            if (cmd_code == CmdLeaveProg && !halted) begin
                push_rsp(KReset, 16'h0, 16'h0);
                halted = 1'b1;
            end
            return;
        end
        case (cmd_code)
            CmdSignOn: begin
                tx(RespSync);
                foreach (SignOnText[i]) tx(SignOnText[i]);
                tx(RespOk);
                ph = PhCmd;
            end
            CmdGetParam: begin
                case (held[0])
                    ParamHwVer:   r = 8'(cfg_hw);
                    ParamSwMaj:   r = 8'(cfg_sw_maj);
                    ParamSwMin:   r = 8'(cfg_sw_min);
                    ParamTopCard: r = TopCardValue;
                    default:      r = 8'h0;
                endcase
                reply_byte(r);
            end
            CmdLeaveProg: begin
                reply_ok();
                push_rsp(KReset, 16'h0, 16'h0);
                halted = 1'b1;
            end
            CmdUniversal: reply_byte(held[1]);
            CmdProgPage: begin
                tgt_addr = tgt_addr << 1;
                byte_cnt = 0;
                if (ee_sel) begin
                    if (page_len == 0) begin
                        reply_ok();
                    end else begin
                        push_rsp(KEeWrite, tgt_addr, {8'h0, page_mem[0]});
                        ph = PhEew;
                    end
                end else begin
                    // odd length: pad the last word with 0xFF
                    if (page_len[0] && page_len <= BufferDepth) begin
                        page_mem[page_len] = 8'hFF;
                        page_len++;
                    end
                    if (page_len == 0) begin
                        reply_ok();
                    end else begin
                        page_words = 0;
                        flash_block();
                    end
                end
            end
            CmdReadPage: begin
                tx(RespSync);
                byte_cnt = 0;
                if (page_len == 0) begin
                    tx(RespOk);
                    ph = PhCmd;
                end else begin
                    issue_read();
                end
            end
            CmdReadSig: begin
                tx(RespSync);
                tx(sig_byte(0));
                tx(sig_byte(1));
                tx(sig_byte(2));
                tx(RespOk);
                ph = PhCmd;
            end
            CmdReadOsc: reply_byte(8'h00);
            default:    reply_ok();
        endcase
    endfunction

    function automatic void host_byte(logic [7:0] v);
        idle_cnt = 0;
        case (ph)
            PhCmd: begin
                cmd_code = v;
                byte_cnt = 0;
                held[0] = 8'h0;
                held[1] = 8'h0;
                if (!known_cmd(v)) count_err();
                else ph = (arg_count(v) == 0) ? PhTerm : PhArgs;
            end
            PhArgs: take_arg(v);
            PhData: begin
                if (byte_cnt < BufferDepth) page_mem[byte_cnt] = v;
                byte_cnt++;
                if (byte_cnt >= page_len) ph = PhTerm;
            end
            PhTerm: terminate(v);
            default: ;   // host bytes are dropped while a memory action is pending
        endcase
    endfunction

    function automatic void mem_done(logic [7:0] v);
        if (ph < PhEew) return;
        idle_cnt = 0;
        case (ph)
            PhEew: begin
                byte_cnt++;
                if (byte_cnt < page_len)
                    push_rsp(KEeWrite, tgt_addr + 16'(byte_cnt), {8'h0, buf_byte(byte_cnt)});
                else
                    reply_ok();
            end
            PhErase: begin
                push_rsp(KRww, tgt_addr, 16'h0);
                ph = PhRww1;
            end
            PhRww1: flash_fill();
            PhFill: begin
                page_words++;
                if (page_words >= PageWords) flash_write_page();
                else flash_advance();
            end
            PhPgw: begin
                push_rsp(KRww, tgt_addr, 16'h0);
                ph = PhRww2;
            end
            PhRww2: flash_advance();
            PhRead: begin
                tx(v);
                tgt_addr = tgt_addr + 16'd1;
                byte_cnt++;
                if (byte_cnt < page_len) begin
                    issue_read();
                end else begin
                    tx(RespOk);
                    ph = PhCmd;
                end
            end
            default: ;
        endcase
    endfunction

    // Advance the shadow engine by one accepted item and queue its results.
    function automatic void engine_step(logic [1:0] op, logic [7:0] v);
        int n0;
        n0 = rsp_expected.size();
        if (halted) return;
        case (op)
            OpHost: host_byte(v);
            OpDone: mem_done(v);
            OpTick: begin
                if (ph < PhEew) begin
                    if (idle_cnt < 'hFFFFFF) idle_cnt++;
                    if (idle_cnt >= cfg_timeout) begin
                        push_rsp(KStartApp, 16'h0, 16'h0);
                        halted = 1'b1;
                    end
                end
            end
            default: ;   // opcode 3 is ignored
        endcase
        if (rsp_expected.size() > n0) rsp_expected[$].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_item(logic [1:0] op, logic [7:0] v);
        if (!quiet && $urandom_range(99) < 22) begin
            cmd_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.opcode <= op;
        cmd_if.value  <= v;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        engine_step(op, v);
    endtask

    // Answer every memory action the engine has outstanding.
    task automatic serve_memory();
        while (!halted && ph >= PhEew) send_item(OpDone, 8'($urandom));
    endtask

    task automatic send_cmd(byte_q_t bytes);
        foreach (bytes[i]) send_item(OpHost, bytes[i]);
        serve_memory();
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        wait (rsp_expected.size() == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 24'(data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            RegMaxErr:  cfg_max_err = data & 'hFF;
            RegTimeout: cfg_timeout = data & 'hFFFFFF;
            RegHwVer:   cfg_hw      = data & 'hFF;
            RegSwMaj:   cfg_sw_maj  = data & 'hFF;
            RegSwMin:   cfg_sw_min  = data & 'hFF;
            RegSig:     cfg_sig     = data & 'hFFFFFF;
            default: ;
        endcase
    endtask

    // page program: length, memory type, data bytes, terminator
    task automatic prog_page(int len, logic [7:0] mem, logic [7:0] term);
        byte_q_t q;
        q = '{CmdProgPage, 8'(len >> 8), 8'(len), mem};
        for (int i = 0; i < ((len > BufferDepth) ? BufferDepth : len); i++)
            q.push_back(8'($urandom));
        q.push_back(term);
        send_cmd(q);
    endtask

    // ------------------------------------------------------------------
    // Result checker and output stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected result kind %0d addr %h payload %h", $time,
                         rsp_if.kind, rsp_if.mem_address, rsp_if.payload);
                fail_count++;
            end else begin
                rsp_t e;
                e = rsp_expected.pop_front();
                if (rsp_if.kind !== e.kind || rsp_if.mem_address !== e.mem_address ||
                    rsp_if.payload !== e.payload || rsp_if.last !== e.last) begin
                    $display("%0t: mismatch expected kind %0d addr %h payload %h last %b",
                             $time, e.kind, e.mem_address, e.payload, e.last);
                    $display("%0t:          actual   kind %0d addr %h payload %h last %b",
                             $time, rsp_if.kind, rsp_if.mem_address, rsp_if.payload,
                             rsp_if.last);
                    fail_count++;
                end
            end
        end
        rsp_if.ready <= quiet || ($urandom_range(99) >= 22);
    end

    // Watchdog: ends the run when neither channel moves for too long.
    int stall_cycles;
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WatchdogLimit) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_simple_commands();
        send_cmd('{CmdGetSync, SyncEop});
        send_cmd('{CmdSignOn, SyncEop});
        send_cmd('{CmdGetParam, ParamHwVer, SyncEop});
        send_cmd('{CmdGetParam, ParamSwMaj, SyncEop});
        send_cmd('{CmdGetParam, ParamSwMin, SyncEop});
        send_cmd('{CmdGetParam, ParamTopCard, SyncEop});
        send_cmd('{CmdGetParam, 8'h00, SyncEop});
        // set parameter takes a second argument above the threshold
        send_cmd('{CmdSetParam, 8'h86, 8'hAA, SyncEop});
        send_cmd('{CmdSetParam, DevExtThresh, SyncEop});
        send_cmd('{CmdSetDevExt, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, SyncEop});
        send_cmd('{CmdEnterProg, SyncEop});
        send_cmd('{CmdChipErase, SyncEop});
        for (int k = 0; k < 4; k++)
            send_cmd('{CmdUniversal, UnivReadSig, 8'h00, 8'(k), 8'h00, SyncEop});
        send_cmd('{CmdUniversal, 8'hA0, 8'h00, 8'h01, 8'h00, SyncEop});
        send_cmd('{CmdReadSig, SyncEop});
        send_cmd('{CmdReadOsc, SyncEop});
        send_cmd('{8'hFF});                     // unknown command
        send_cmd('{CmdGetSync, 8'h00});         // bad terminator
        send_item(2'd3, 8'hFF);                 // reserved opcode, ignored
        send_item(OpDone, 8'h00);               // completion with nothing pending
    endtask

    task automatic test_set_device();
        byte_q_t q;
        q = '{CmdSetDevice};
        repeat (20) q.push_back(8'($urandom));
        q.push_back(SyncEop);
        send_cmd(q);
    endtask

    task automatic test_page_program();
        send_cmd('{CmdLoadAddr, 8'h34, 8'h12, SyncEop});
        prog_page(3, MemEeprom, SyncEop);
        prog_page(3, 8'h46, SyncEop);           // odd flash length, padded
        prog_page(0, 8'h46, SyncEop);           // zero length: reply only
        prog_page(0, MemEeprom, SyncEop);
        send_cmd('{CmdLoadAddr, 8'hFF, 8'hFF, SyncEop});
        // oversize length saturates: 256 data bytes, two full pages
        prog_page(16'h0105, 8'h46, SyncEop);
        send_cmd('{CmdReadPage, 8'h00, 8'h04, MemEeprom, SyncEop});
        send_cmd('{CmdReadPage, 8'h00, 8'h03, 8'h46, SyncEop});
        send_cmd('{CmdReadPage, 8'h00, 8'h00, 8'h46, SyncEop});
        send_cmd('{CmdReadPage, 8'h00, 8'h02, 8'h46, 8'h21});   // bad terminator
        // EEPROM page program of two data bytes
        send_cmd('{CmdProgPage, 8'h00, 8'h02, MemEeprom, 8'h5A, 8'hA5, SyncEop});
    endtask

    task automatic test_ignored_while_busy();
        send_cmd('{CmdProgPage, 8'h00, 8'h02, 8'h46, 8'h11, 8'h22});
        send_item(OpHost, SyncEop);
        send_item(OpHost, 8'h30);
        send_item(OpTick, 8'h00);
        serve_memory();
    endtask

    task automatic test_timeout_count();
        drain();
        write_reg(RegTimeout, 3);
        send_item(OpTick, 8'h00);
        send_item(OpTick, 8'h00);
        send_cmd('{CmdGetSync, SyncEop});   // host byte clears the count
        send_item(OpTick, 8'h00);
        send_item(OpTick, 8'h00);
        drain();
        write_reg(RegTimeout, 'hFFFFFF);
    endtask

    task automatic test_config_values();
        drain();
        write_reg(RegHwVer, 0);
        write_reg(RegSwMaj, 255);
        write_reg(RegSwMin, $urandom_range(255));
        write_reg(RegSig, 0);
        send_cmd('{CmdGetParam, ParamHwVer, SyncEop});
        send_cmd('{CmdGetParam, ParamSwMaj, SyncEop});
        send_cmd('{CmdGetParam, ParamSwMin, SyncEop});
        send_cmd('{CmdReadSig, SyncEop});
        drain();
        write_reg(RegHwVer, 255);
        write_reg(RegSwMaj, 0);
        write_reg(RegSig, 'hFFFFFF);
        write_reg(RegMaxErr, 0);
        write_reg(RegMaxErr, 255);          // random part makes errors freely
        send_cmd('{CmdGetParam, ParamHwVer, SyncEop});
        send_cmd('{CmdUniversal, UnivReadSig, 8'h00, 8'h02, 8'h00, SyncEop});
        send_cmd('{CmdReadSig, SyncEop});
        drain();
        write_reg(RegSig, $urandom_range('hFFFFFF));
    endtask

    task automatic random_command();
        byte_q_t q;
        logic [7:0] term;
        int len;
        term = ($urandom_range(9) == 0) ? 8'($urandom) : SyncEop;
        case ($urandom_range(11))
            0: q = '{CmdGetSync};
            1: q = '{CmdSignOn};
            2: q = '{CmdGetParam, 8'($urandom_range(3) == 0 ? $urandom : 'h80 + $urandom_range(2))};
            3: q = '{CmdSetParam, 8'($urandom), 8'($urandom)};
            4: q = '{CmdLoadAddr, 8'($urandom), 8'($urandom)};
            5: q = '{CmdUniversal, 8'($urandom_range(1) ? UnivReadSig : $urandom),
                     8'($urandom), 8'($urandom_range(3)), 8'($urandom)};
            6: q = '{CmdReadSig};
            7: q = '{CmdReadOsc};
            8, 9: begin
                len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(8);
                q = '{CmdProgPage, 8'(len >> 8), 8'(len),
                      $urandom_range(1) ? MemEeprom : 8'($urandom)};
                for (int i = 0; i < ((len > BufferDepth) ? BufferDepth : len); i++)
                    q.push_back(8'($urandom));
            end
            10: q = '{CmdReadPage, 8'h00, 8'($urandom_range(8)),
                      $urandom_range(1) ? MemEeprom : 8'($urandom)};
            default: q = '{CmdEnterProg};
        endcase
        q.push_back(term);
        send_cmd(q);
    endtask

    task automatic random_noise();
        logic [1:0] op;
        logic [7:0] v;
        op = 2'($urandom);
        v  = 8'($urandom);
        // leaving programming mode would halt the engine for good
        if (op == OpHost && ph == PhCmd && v == CmdLeaveProg) v = CmdEnterProg;
        send_item(op, v);
        serve_memory();
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < 100; n++) begin
            quiet = (n >= 40 && n < 60);
            if ($urandom_range(4) == 0) random_noise();
            else random_command();
        end
        quiet = 1'b0;
    endtask

    task automatic test_leave_programming();
        drain();
        write_reg(RegTimeout, 1);
        send_cmd('{CmdLeaveProg, SyncEop});
        // engine is halted: everything below is ignored
        send_item(OpTick, 8'h00);
        send_item(OpHost, CmdGetSync);
        send_item(OpDone, 8'h00);
    endtask

    initial begin
        cfg_max_err = 10;
        cfg_timeout = 1000000;
        cfg_hw = 2;
        cfg_sw_maj = 1;
        cfg_sw_min = 16;
        cfg_sig = 'h1E950F;
        ph = PhCmd;
        cmd_code = 8'h0;
        byte_cnt = 0;
        page_len = 0;
        tgt_addr = 16'h0;
        err_cnt = 0;
        idle_cnt = 0;
        ee_sel = 1'b0;
        page_words = 0;
        held = '{8'h0, 8'h0};
        halted = 1'b0;
        fail_count = 0;
        quiet = 1'b0;
        foreach (page_mem[i]) page_mem[i] = 8'h0;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= RegMaxErr;
        i_cfg_data    <= 24'h0;
        cmd_if.valid  <= 1'b0;
        cmd_if.opcode <= OpHost;
        cmd_if.value  <= 8'h0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_simple_commands();
        test_set_device();
        test_page_program();
        test_ignored_while_busy();
        test_timeout_count();
        test_config_values();
        test_random_traffic();
        test_leave_programming();

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && rsp_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
